// ===== rtl/heartbeat_membership_table_macros.svh =====
// Assertion macros for the membership table.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef HEARTBEAT_MEMBERSHIP_TABLE_MACROS_SVH
`define HEARTBEAT_MEMBERSHIP_TABLE_MACROS_SVH

// Same-cycle implication under reset.
`define HBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define HBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hbm_pkg.sv =====
// Shared types, codes and helpers for the heartbeat membership table.
// No dependencies.
package hbm_pkg;

    // Commands
    localparam logic [1:0] CMD_JOIN_REQ = 2'd0;
    localparam logic [1:0] CMD_JOIN_REP = 2'd1;
    localparam logic [1:0] CMD_MERGE    = 2'd2;
    localparam logic [1:0] CMD_SWEEP    = 2'd3;

    // Event codes
    localparam logic [2:0] EV_IGNORED   = 3'd0;
    localparam logic [2:0] EV_ADDED     = 3'd1;
    localparam logic [2:0] EV_REFRESHED = 3'd2;
    localparam logic [2:0] EV_REMOVED   = 3'd3;
    localparam logic [2:0] EV_FULL      = 3'd4;
    localparam logic [2:0] EV_SWEEP     = 3'd5;

    // Config register indexes
    localparam logic [1:0] REG_SELF_ID   = 2'd0;
    localparam logic [1:0] REG_SELF_PORT = 2'd1;
    localparam logic [1:0] REG_FAIL_TO   = 2'd2;
    localparam logic [1:0] REG_REMOVE_TO = 2'd3;

    // Heartbeat given to a member added by a join request
    localparam logic [31:0] HB_INIT = 32'd1;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] heartbeat;
        logic [31:0] stamp;
    } entry_t;

    // stamp + limit <= now, without wrap
    function automatic logic past_limit(input logic [31:0] stamp,
                                        input logic [15:0] limit,
                                        input logic [31:0] now);
        logic [32:0] sum;
        sum = {1'b0, stamp} + {17'b0, limit};
        return sum <= {1'b0, now};
    endfunction

endpackage

// ===== rtl/hbm_in_if.sv =====
// Input item channel of the membership table.
// Depends on nothing.
interface hbm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] member_id;
    logic [15:0] member_port;
    logic [31:0] member_heartbeat;
    logic [31:0] member_stamp;
    logic [31:0] current_time;

    modport source (output valid, command, member_id, member_port, member_heartbeat,
                    member_stamp, current_time, input ready);
    modport sink (input valid, command, member_id, member_port, member_heartbeat,
                  member_stamp, current_time, output ready);
endinterface

// ===== rtl/hbm_out_if.sv =====
// Result item channel of the membership table.
// Depends on nothing.
interface hbm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [31:0] event_id;
    logic [15:0] event_port;
    logic [5:0]  entry_count;
    logic        joined;
    logic        last;

    modport source (output valid, event_res, event_id, event_port, entry_count, joined,
                    last, input ready);
    modport sink (input valid, event_res, event_id, event_port, entry_count, joined,
                  last, output ready);
endinterface

// ===== rtl/hbm_entry_ram.sv =====
// Entry storage: one write port, one read port, registered read data.
// Depends on hbm_pkg for the entry type.
module hbm_entry_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  hbm_pkg::entry_t wdata,
    input  logic           re,
    input  logic [AW-1:0]  raddr,
    output hbm_pkg::entry_t rdata
);
    import hbm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/heartbeat_membership_table.sv =====
// Join and merge items search the table one entry at a time (read, then compare), then add
// or refresh; a removal by merge then compacts the entries from the removed one onward.
// A sweep reads and compacts every entry. Any wait on the result side stalls all of these.
// One item at a time; a new item is taken only once the table walk for the last one is done.
// Reset: table empty, not in group, config at its defaults. No clearing pass.
module heartbeat_membership_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hbm_in_if.sink      in_ch,
    hbm_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import hbm_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SR_RD  = 3'd1;
    localparam logic [2:0] ST_SR_CHK = 3'd2;
    localparam logic [2:0] ST_CP_RD  = 3'd3;
    localparam logic [2:0] ST_CP_CHK = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    // config
    logic [31:0] self_id_reg;
    logic [15:0] self_port_reg;
    logic [15:0] fail_to_reg;
    logic [15:0] remove_to_reg;

    // control
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic          group_reg, group_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] end_reg, end_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          sweep_reg, sweep_next;
    logic [2:0]    res_reg, res_next;

    // item payload
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] id_reg, id_next;
    logic [15:0] port_reg, port_next;
    logic [31:0] hb_reg, hb_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] now_reg, now_next;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_res_reg;
    logic [31:0] out_id_reg;
    logic [15:0] out_port_reg;
    logic [5:0]  out_count_reg;
    logic        out_joined_reg;
    logic        out_last_reg;

    logic        out_load;
    logic [2:0]  out_res;
    logic [31:0] out_id;
    logic [15:0] out_port;
    logic        out_last;
    logic        slot_free;
    logic        in_fire;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;

    logic          drop;
    logic          cp_ptrs_ok;

    hbm_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign slot_free   = !out_valid_reg || out_ch.ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg   <= '0;
            self_port_reg <= '0;
            fail_to_reg   <= 16'd5;
            remove_to_reg <= 16'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SELF_ID:   self_id_reg   <= cfg_data;
                REG_SELF_PORT: self_port_reg <= cfg_data[15:0];
                REG_FAIL_TO:   fail_to_reg   <= cfg_data[15:0];
                REG_REMOVE_TO: remove_to_reg <= cfg_data[15:0];
                default:       self_id_reg   <= self_id_reg;
            endcase
        end
    end

    // sequencer: search, add/refresh, compaction, result hand-off
    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        group_next = group_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        end_next   = end_reg;
        idx_next   = idx_reg;
        sweep_next = sweep_reg;
        res_next   = res_reg;
        cmd_next   = cmd_reg;
        id_next    = id_reg;
        port_next  = port_reg;
        hb_next    = hb_reg;
        stamp_next = stamp_reg;
        now_next   = now_reg;

        ram_we    = 1'b0;
        ram_waddr = rd_reg[AW-1:0];
        ram_wdata = '{id: id_reg, port: port_reg, heartbeat: hb_reg, stamp: stamp_reg};
        ram_re    = 1'b0;
        ram_raddr = rd_reg[AW-1:0];

        out_load = 1'b0;
        out_res  = res_reg;
        out_id   = id_reg;
        out_port = port_reg;
        out_last = 1'b1;

        drop = sweep_reg ? past_limit(ram_rdata.stamp, remove_to_reg, now_reg)
                         : (rd_reg == idx_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = in_ch.command;
                    id_next    = in_ch.member_id;
                    port_next  = in_ch.member_port;
                    hb_next    = in_ch.member_heartbeat;
                    stamp_next = in_ch.member_stamp;
                    now_next   = in_ch.current_time;
                    rd_next    = '0;
                    if (in_ch.command == CMD_SWEEP)
                    begin
                        sweep_next = 1'b1;
                        wr_next    = '0;
                        end_next   = occ_reg;
                        state_next = ST_CP_RD;
                    end
                    else if (in_ch.member_id == self_id_reg &&
                             in_ch.member_port == self_port_reg)
                    begin
                        res_next   = EV_IGNORED;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SR_RD;
                    end
                end
            end

            ST_SR_RD:
            begin
                if (rd_reg == occ_reg)
                begin
                    // not in the table
                    state_next = ST_EMIT;
                    if (cmd_reg == CMD_MERGE &&
                        (past_limit(stamp_reg, remove_to_reg, now_reg) ||
                         past_limit(stamp_reg, fail_to_reg, now_reg)))
                    begin
                        res_next = EV_IGNORED;
                    end
                    else if (occ_reg == DEPTH_C)
                    begin
                        res_next = EV_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = occ_reg[AW-1:0];
                        if (cmd_reg == CMD_JOIN_REQ)
                        begin
                            ram_wdata.heartbeat = HB_INIT;
                            ram_wdata.stamp     = now_reg;
                        end
                        occ_next = occ_reg + CW'(1);
                        res_next = EV_ADDED;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_SR_CHK;
                end
            end

            ST_SR_CHK:
            begin
                if (ram_rdata.id == id_reg && ram_rdata.port == port_reg)
                begin
                    if (cmd_reg != CMD_MERGE)
                    begin
                        res_next   = EV_IGNORED;
                        state_next = ST_EMIT;
                    end
                    else if (past_limit(stamp_reg, remove_to_reg, now_reg))
                    begin
                        // close the gap from the matched slot onward
                        sweep_next = 1'b0;
                        idx_next   = rd_reg;
                        wr_next    = rd_reg;
                        end_next   = occ_reg;
                        state_next = ST_CP_RD;
                    end
                    else if (ram_rdata.heartbeat < hb_reg)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.stamp = now_reg;
                        res_next        = EV_REFRESHED;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        res_next   = EV_IGNORED;
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    rd_next    = rd_reg + CW'(1);
                    state_next = ST_SR_RD;
                end
            end

            ST_CP_RD:
            begin
                if (rd_reg == end_reg)
                begin
                    state_next = ST_EMIT;
                    if (sweep_reg)
                    begin
                        res_next  = EV_SWEEP;
                        id_next   = '0;
                        port_next = '0;
                    end
                    else
                    begin
                        res_next = EV_REMOVED;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_CP_CHK;
                end
            end

            ST_CP_CHK:
            begin
                if (drop)
                begin
                    if (!sweep_reg)
                    begin
                        occ_next   = occ_reg - CW'(1);
                        rd_next    = rd_reg + CW'(1);
                        state_next = ST_CP_RD;
                    end
                    else if (slot_free)
                    begin
                        out_load   = 1'b1;
                        out_res    = EV_REMOVED;
                        out_id     = ram_rdata.id;
                        out_port   = ram_rdata.port;
                        out_last   = 1'b0;
                        occ_next   = occ_reg - CW'(1);
                        rd_next    = rd_reg + CW'(1);
                        state_next = ST_CP_RD;
                    end
                end
                else
                begin
                    // keep: move down to the write pointer
                    ram_we     = 1'b1;
                    ram_waddr  = wr_reg[AW-1:0];
                    ram_wdata  = ram_rdata;
                    wr_next    = wr_reg + CW'(1);
                    rd_next    = rd_reg + CW'(1);
                    state_next = ST_CP_RD;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (cmd_reg == CMD_JOIN_REP)
                    begin
                        group_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            group_reg <= 1'b0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            end_reg   <= '0;
            idx_reg   <= '0;
            sweep_reg <= 1'b0;
            res_reg   <= EV_IGNORED;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            group_reg <= group_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            end_reg   <= end_next;
            idx_reg   <= idx_next;
            sweep_reg <= sweep_next;
            res_reg   <= res_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        id_reg    <= id_next;
        port_reg  <= port_next;
        hb_reg    <= hb_next;
        stamp_reg <= stamp_next;
        now_reg   <= now_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg    <= out_res;
            out_id_reg     <= out_id;
            out_port_reg   <= out_port;
            out_count_reg  <= 6'(occ_next);
            out_joined_reg <= group_next;
            out_last_reg   <= out_last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.event_res   = out_res_reg;
    assign out_ch.event_id    = out_id_reg;
    assign out_ch.event_port  = out_port_reg;
    assign out_ch.entry_count = out_count_reg;
    assign out_ch.joined      = out_joined_reg;
    assign out_ch.last        = out_last_reg;

    // checks
    assign cp_ptrs_ok = (wr_reg <= rd_reg) && (rd_reg < end_reg);

`include "heartbeat_membership_table_macros.svh"

    `HBM_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= DEPTH_C, "occupancy beyond table depth")
    `HBM_ASSERT_NEXT(a_busy_after_accept, in_fire, state_reg != ST_IDLE, "idle after accept")
    `HBM_ASSERT_NOW(a_compact_ptrs, state_reg == ST_CP_CHK, cp_ptrs_ok, "pointers crossed")
    `HBM_ASSERT_NOW(a_no_overwrite, out_load, slot_free, "result loaded over a waiting result")

endmodule
